// ===== rtl/two_pass_crc32c_hash_assert.svh =====
// assertion macros used by the hash block checker
`ifndef TWO_PASS_CRC32C_HASH_ASSERT_SVH
`define TWO_PASS_CRC32C_HASH_ASSERT_SVH

// clocked check, muted while reset is held
`define TPCH_ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs through reset
`define TPCH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/tpch_pkg.sv =====
// constants, types and crc helper functions for the two pass crc32c hash
`default_nettype none

package tpch_pkg;

    localparam int MAX_WORDS = 512;
    localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 136;

    localparam logic [31:0] SEED_A      = 32'h1F0D3804;
    localparam logic [31:0] SEED_B      = 32'hA9BFE7C1;
    localparam logic [31:0] MIX_C       = 32'h5BD1E995;
    localparam logic [31:0] MIX_D       = 32'h1B873593;
    localparam logic [31:0] CRC_POLY    = 32'h82F63B78;
    localparam logic [63:0] GOLDEN_MASK = 64'h9E3779B97F4A7C15;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FOLD_AB,
        ST_SEED,
        ST_P2_C,
        ST_P2_D,
        ST_FOLD_CD,
        ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        LOP_HOLD,
        LOP_WORD_AB,
        LOP_BYTE_AB,
        LOP_SEED_CD,
        LOP_WORD_C,
        LOP_WORD_D,
        LOP_BYTE_CD,
        LOP_CLEAR
    } lane_op_t;

    typedef struct packed {
        lane_op_t   op;
        logic       tail_load;
        logic [2:0] byte_idx;
        logic       out_load;
    } lane_ctrl_t;

    // bit-serial reflected crc, only evaluated at elaboration to build the xor maps
    function automatic logic [31:0] crc_serial(input logic [31:0] crc_in,
                                               input logic [63:0] data,
                                               input int nbits);
        logic [31:0] crc;
        logic        fb;
        crc = crc_in;
        for (int k = 0; k < 64; k++) begin
            if (k < nbits) begin
                fb  = crc[0] ^ data[k];
                crc = {1'b0, crc[31:1]} ^ (CRC_POLY & {32{fb}});
            end
        end
        return crc;
    endfunction

    function automatic logic [31:0][31:0] gen_state_cols(input int nbits);
        logic [31:0][31:0] cols;
        for (int i = 0; i < 32; i++) begin
            cols[i] = crc_serial(32'h1 << i, 64'h0, nbits);
        end
        return cols;
    endfunction

    function automatic logic [63:0][31:0] gen_word_data_cols();
        logic [63:0][31:0] cols;
        for (int k = 0; k < 64; k++) begin
            cols[k] = crc_serial(32'h0, 64'h1 << k, 64);
        end
        return cols;
    endfunction

    function automatic logic [7:0][31:0] gen_byte_data_cols();
        logic [7:0][31:0] cols;
        for (int k = 0; k < 8; k++) begin
            cols[k] = crc_serial(32'h0, 64'h1 << k, 8);
        end
        return cols;
    endfunction

    // column maps: contribution of each state and data bit to the crc after one step
    localparam logic [31:0][31:0] WORD_STATE_COLS = gen_state_cols(64);
    localparam logic [63:0][31:0] WORD_DATA_COLS  = gen_word_data_cols();
    localparam logic [31:0][31:0] BYTE_STATE_COLS = gen_state_cols(8);
    localparam logic [7:0][31:0]  BYTE_DATA_COLS  = gen_byte_data_cols();

    // crc32c over eight bytes as a flat xor network
    function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [63:0] w);
        logic [31:0] acc;
        acc = 32'h0;
        for (int i = 0; i < 32; i++) begin
            if (crc[i]) acc = acc ^ WORD_STATE_COLS[i];
        end
        for (int k = 0; k < 64; k++) begin
            if (w[k]) acc = acc ^ WORD_DATA_COLS[k];
        end
        return acc;
    endfunction

    // crc32c over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] acc;
        acc = 32'h0;
        for (int i = 0; i < 32; i++) begin
            if (crc[i]) acc = acc ^ BYTE_STATE_COLS[i];
        end
        for (int k = 0; k < 8; k++) begin
            if (b[k]) acc = acc ^ BYTE_DATA_COLS[k];
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tpch_word_ram.sv =====
// simple dual port word store with registered read data
`default_nettype none

module tpch_word_ram #(
    parameter int DEPTH  = 512,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tpch_lanes.sv =====
// crc lane registers a to d and the tail word
`default_nettype none

module tpch_lanes
    import tpch_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire lane_ctrl_t  ctrl,
    input  wire logic [63:0] in_word,
    input  wire logic [63:0] ram_q,
    output logic      [31:0] lane_a,
    output logic      [31:0] lane_b,
    output logic      [31:0] lane_c,
    output logic      [31:0] lane_d
);

    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] d_reg, d_next;
    logic [63:0] tail_reg;
    logic [7:0]  tail_byte;

    assign tail_byte = tail_reg[{ctrl.byte_idx, 3'b000} +: 8];

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        case (ctrl.op)
            LOP_WORD_AB: begin
                a_next = crc_word(a_reg, in_word);
                b_next = crc_word(b_reg, in_word ^ GOLDEN_MASK);
            end
            LOP_BYTE_AB: begin
                a_next = crc_byte(a_reg, tail_byte);
                b_next = crc_byte(b_reg, tail_byte);
            end
            LOP_SEED_CD: begin
                c_next = a_reg ^ MIX_C;
                d_next = b_reg ^ MIX_D;
            end
            LOP_WORD_C: begin
                c_next = crc_word(c_reg, ram_q ^ {32'h0, d_reg});
            end
            LOP_WORD_D: begin
                d_next = crc_word(d_reg, ram_q ^ {32'h0, c_reg});
            end
            LOP_BYTE_CD: begin
                c_next = crc_byte(c_reg, tail_byte);
                d_next = crc_byte(d_reg, tail_byte);
            end
            LOP_CLEAR: begin
                a_next = SEED_A;
                b_next = SEED_B;
            end
            default: begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= SEED_A;
            b_reg <= SEED_B;
        end else begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg <= c_next;
        d_reg <= d_next;
        if (ctrl.tail_load) begin
            tail_reg <= in_word;
        end
    end

    assign lane_a = a_reg;
    assign lane_b = b_reg;
    assign lane_c = c_reg;
    assign lane_d = d_reg;

endmodule

`default_nettype wire

// ===== rtl/tpch_seq.sv =====
// sequencer: load pass, tail folds, second pass over the store, result hand-off
`default_nettype none

module tpch_seq
    import tpch_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    input  wire logic [3:0]        byte_count,
    input  wire logic              out_free,
    output logic                   s_tready,
    output lane_ctrl_t             ctrl,
    output logic                   ram_we,
    output logic      [ADDR_W-1:0] ram_waddr,
    output logic                   ram_re,
    output logic      [ADDR_W-1:0] ram_raddr,
    output logic                   overflow,
    output logic                   framing_error
);

    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [2:0]       byte_idx_reg, byte_idx_next;
    logic [2:0]       tail_n_reg, tail_n_next;
    logic             ovf_reg, ovf_next;
    logic             frm_reg, frm_next;
    logic             full_word;
    logic             tail_end;
    seq_state_t       after_pass;

    assign full_word  = (byte_count >= 4'd8);
    assign tail_end   = (3'(byte_idx_reg + 3'd1) == tail_n_reg);
    assign after_pass = (tail_n_reg == 3'd0) ? ST_DONE : ST_FOLD_CD;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rd_idx_next   = rd_idx_reg;
        byte_idx_next = byte_idx_reg;
        tail_n_next   = tail_n_reg;
        ovf_next      = ovf_reg;
        frm_next      = frm_reg;
        s_tready      = 1'b0;
        ctrl.op        = LOP_HOLD;
        ctrl.tail_load = 1'b0;
        ctrl.byte_idx  = byte_idx_reg;
        ctrl.out_load  = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = rd_idx_reg[ADDR_W-1:0];
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (full_word) begin
                        ctrl.op = LOP_WORD_AB;
                        if (cnt_reg < CNT_W'(MAX_WORDS)) begin
                            ram_we   = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                        if (s_tlast) begin
                            tail_n_next = 3'd0;
                            state_next  = ST_SEED;
                        end
                    end else if (!s_tlast) begin
                        frm_next = 1'b1;
                    end else begin
                        ctrl.tail_load = 1'b1;
                        tail_n_next    = byte_count[2:0];
                        byte_idx_next  = 3'd0;
                        state_next     = (byte_count == 4'd0) ? ST_SEED : ST_FOLD_AB;
                    end
                end
            end
            ST_FOLD_AB: begin
                ctrl.op       = LOP_BYTE_AB;
                byte_idx_next = 3'(byte_idx_reg + 3'd1);
                if (tail_end) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: begin
                ctrl.op       = LOP_SEED_CD;
                byte_idx_next = 3'd0;
                if (cnt_reg == '0) begin
                    state_next = after_pass;
                end else begin
                    ram_re      = 1'b1;
                    ram_raddr   = '0;
                    rd_idx_next = CNT_W'(1);
                    state_next  = ST_P2_C;
                end
            end
            ST_P2_C: begin
                ctrl.op    = LOP_WORD_C;
                state_next = ST_P2_D;
            end
            ST_P2_D: begin
                ctrl.op = LOP_WORD_D;
                if (rd_idx_reg == cnt_reg) begin
                    state_next = after_pass;
                end else begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    state_next  = ST_P2_C;
                end
            end
            ST_FOLD_CD: begin
                ctrl.op       = LOP_BYTE_CD;
                byte_idx_next = 3'(byte_idx_reg + 3'd1);
                if (tail_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctrl.out_load = 1'b1;
                    ctrl.op       = LOP_CLEAR;
                    cnt_next      = '0;
                    tail_n_next   = 3'd0;
                    ovf_next      = 1'b0;
                    frm_next      = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            cnt_reg      <= '0;
            rd_idx_reg   <= '0;
            byte_idx_reg <= 3'd0;
            tail_n_reg   <= 3'd0;
            ovf_reg      <= 1'b0;
            frm_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_idx_reg   <= rd_idx_next;
            byte_idx_reg <= byte_idx_next;
            tail_n_reg   <= tail_n_next;
            ovf_reg      <= ovf_next;
            frm_reg      <= frm_next;
        end
    end

    assign ram_waddr     = cnt_reg[ADDR_W-1:0];
    assign overflow      = ovf_reg;
    assign framing_error = frm_reg;

endmodule

`default_nettype wire

// ===== rtl/two_pass_crc32c_hash.sv =====
// top level of the two pass crc32c message hash
`default_nettype none

// Two pass CRC32C hash over a message of little-endian 64-bit words. Each input
// item carries a word, its byte count and tlast. A full word (count eight or
// more) is folded into raw crc lanes a and b (b sees the word xor a golden-ratio
// mask) and written to the on-chip word store, 512 entries; words past that
// still feed a and b but set the overflow flag. A short word that is not last
// is dropped and sets the framing flag. On the last item the block stops taking
// input: tail bytes are folded into a and b one byte per cycle, then lanes c and
// d are seeded from a and b and a second pass reads the store back, each stored
// word going into c, then into d over the new c, off one registered memory
// read; then the tail bytes go into c and d one per cycle. The result waits in
// an output register, so loading of the next message starts while it is still
// pending. The store needs no clearing: only entries written during the current
// message are read back.
module two_pass_crc32c_hash
    import tpch_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // data_word [63:0], byte_count [67:64], zero pad [71:68]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // hash_word_a [31:0], hash_word_b [63:32], hash_word_c [95:64],
    // hash_word_d [127:96], overflow [128], framing_error [129], zero pad [135:130]
    output logic      [M_TDATA_W-1:0] m_tdata
);

    lane_ctrl_t          ctrl;
    logic [63:0]         data_word;
    logic [3:0]          byte_count;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [63:0]         ram_q;
    logic [31:0]         lane_a, lane_b, lane_c, lane_d;
    logic                ovf_flag, frm_flag;
    logic                out_free;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // unpack the input item
    assign data_word  = s_tdata[63:0];
    assign byte_count = s_tdata[67:64];

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    tpch_seq u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tlast       (s_tlast),
        .byte_count    (byte_count),
        .out_free      (out_free),
        .s_tready      (s_tready),
        .ctrl          (ctrl),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .overflow      (ovf_flag),
        .framing_error (frm_flag)
    );

    // message word store
    tpch_word_ram #(
        .DEPTH  (MAX_WORDS),
        .WIDTH  (64),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (data_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    tpch_lanes u_lanes (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .in_word (data_word),
        .ram_q   (ram_q),
        .lane_a  (lane_a),
        .lane_b  (lane_b),
        .lane_c  (lane_c),
        .lane_d  (lane_d)
    );

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_tdata_reg <= {6'b0, frm_flag, ovf_flag, lane_d, lane_c, lane_b, lane_a};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tpch_checker.sv =====
// port level checks for the hash block and their bind
`default_nettype none

`include "two_pass_crc32c_hash_assert.svh"

module tpch_checker
    import tpch_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 s_tlast,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a pending result holds until taken
    `TPCH_ASSERT_ON(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // reset empties the result register
    `TPCH_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid, "result valid after reset")

    // the block leaves loading right after a last item, so input stalls
    `TPCH_ASSERT_ON(a_busy_after_last, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken during second pass")

    // a new result is loaded only while input is held off
    `TPCH_ASSERT_ON(a_result_from_pass, $rose(m_tvalid) |-> $past(!s_tready), "result loaded while loading")

endmodule

bind two_pass_crc32c_hash tpch_checker u_tpch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
